/* rtl/css_pkg.sv */
// Shared types, constants and the weight coefficient function for the
// cardinal spline segment evaluator. No dependencies.
`default_nettype none

package css_pkg;

	// default values for the top-level parameters
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 24;

	// fixed field widths
	localparam int IDX_W  = 6;
	localparam int T_W    = 16;
	localparam int TEN_W  = 15;
	localparam int PIU_W  = 7;
	localparam int CFG_W  = 15;
	localparam int CIDX_W = 1;

	// arithmetic widths
	localparam int COEF_W = 18;   // signed weight coefficient, Q3.14
	localparam int PW_W   = 32;   // powers of t in Q0.32
	localparam int WACC_W = 52;   // weight accumulator, Q.46
	localparam int WSHIFT = 22;   // Q.46 down to Q.24
	localparam int WQ_W   = WACC_W - WSHIFT;
	localparam int CSHIFT = 24;   // Q.32 sum down to Q.8

	// register reset values
	localparam logic [TEN_W-1:0] TENSION_RESET = 15'd8192;
	localparam logic [PIU_W-1:0] POINTS_RESET  = 7'd64;

	// fixed-point constants
	localparam logic signed [COEF_W-1:0] TWO_Q14   = 18'sd32768;
	localparam logic signed [COEF_W-1:0] THREE_Q14 = 18'sd49152;
	localparam logic signed [WACC_W-1:0] W_ONE     = 52'sh4000_0000_0000;
	localparam logic signed [WACC_W-1:0] W_HALF    = 52'sh0000_0020_0000;

	// input action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_TENSION = 1'b0;
	localparam logic [CIDX_W-1:0] REG_POINTS  = 1'b1;

	// weight term steps
	localparam logic [1:0] WS_T1 = 2'd0;
	localparam logic [1:0] WS_T2 = 2'd1;
	localparam logic [1:0] WS_T3 = 2'd2;

	// last point step of the position sum
	localparam logic [1:0] LAST_MSTEP = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       wr;
		logic       wgt;
		logic [1:0] wstep;
		logic       rnd;
		logic       rd;
		logic [1:0] rd_k;
		logic       mac;
		logic [1:0] mstep;
		logic       fin;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

	// coefficient of one power of t in weight k, c in Q1.14
	function automatic logic signed [COEF_W-1:0] wcoef(
		input logic [1:0]       k,
		input logic [1:0]       step,
		input logic [TEN_W-1:0] c
	);
		logic signed [COEF_W-1:0] cs;
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] r;
		logic signed [COEF_W-1:0] res;
		cs = $signed({{(COEF_W-TEN_W){1'b0}}, c});
		case (k)
			2'd0: begin
				a = -cs;
				b = cs <<< 1;
				r = -cs;
			end
			2'd1: begin
				a = '0;
				b = cs - THREE_Q14;
				r = TWO_Q14 - cs;
			end
			2'd2: begin
				a = cs;
				b = THREE_Q14 - (cs <<< 1);
				r = cs - TWO_Q14;
			end
			default: begin
				a = '0;
				b = -cs;
				r = cs;
			end
		endcase
		case (step)
			WS_T1:   res = a;
			WS_T2:   res = b;
			default: res = r;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

/* rtl/css_ctrl.sv */
// Controller state machine of the spline evaluator: accepts items and
// sequences the datapath. Depends on css_pkg.
`default_nettype none

module css_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               in_action,
	input  wire css_pkg::dp_sts_t   sts,
	output css_pkg::dp_cmd_t        cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_W0   = 7'b0000010,
		ST_W1   = 7'b0000100,
		ST_W2   = 7'b0001000,
		ST_RND  = 7'b0010000,
		ST_MAC  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] step_q, step_d;
	logic       accept;

	assign accept = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					cmd.load = 1'b1;
					if (in_action == css_pkg::ACT_EVAL) begin
						state_d = ST_W0;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_W0: begin
				cmd.wgt   = 1'b1;
				cmd.wstep = css_pkg::WS_T1;
				state_d   = ST_W1;
			end
			ST_W1: begin
				cmd.wgt   = 1'b1;
				cmd.wstep = css_pkg::WS_T2;
				state_d   = ST_W2;
			end
			ST_W2: begin
				cmd.wgt   = 1'b1;
				cmd.wstep = css_pkg::WS_T3;
				state_d   = ST_RND;
			end
			ST_RND: begin
				cmd.rnd  = 1'b1;
				cmd.rd   = 1'b1;
				cmd.rd_k = 2'd0;
				step_d   = 2'd0;
				state_d  = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac   = 1'b1;
				cmd.mstep = step_q;
				if (step_q == css_pkg::LAST_MSTEP) begin
					state_d = ST_FIN;
				end else begin
					cmd.rd   = 1'b1;
					cmd.rd_k = step_q + 2'd1;
					step_d   = step_q + 2'd1;
				end
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// result register is never loaded while it still holds an untaken result
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !sts.out_busy)
		else $error("result loaded while output register busy");

	// an accepted evaluate starts the weight sequence
	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_action == css_pkg::ACT_EVAL) |=> state_q == ST_W0)
		else $error("evaluate did not start weight sequence");

	// the fourth point step ends the position sum
	a_mac_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && step_q == css_pkg::LAST_MSTEP) |=> state_q == ST_FIN)
		else $error("position sum did not end after fourth point");

endmodule

`default_nettype wire

/* rtl/css_dp.sv */
// Datapath of the spline evaluator: control point memory, configuration
// registers, weight units, position sum and result register. Depends on css_pkg.
`default_nettype none

module css_dp #(
	parameter int MAX_POINTS = css_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = css_pkg::COORD_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire css_pkg::dp_cmd_t                      cmd,
	output css_pkg::dp_sts_t                           sts,
	input  wire logic [css_pkg::IDX_W-1:0]             in_index,
	input  wire logic signed [COORD_BITS-1:0]          in_x,
	input  wire logic signed [COORD_BITS-1:0]          in_y,
	input  wire logic [css_pkg::T_W-1:0]               in_t,
	input  wire logic                                  cfg_we,
	input  wire logic [css_pkg::CIDX_W-1:0]            cfg_index,
	input  wire logic [css_pkg::CFG_W-1:0]             cfg_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [COORD_BITS-1:0]               out_x,
	output logic signed [COORD_BITS-1:0]               out_y
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int IXW   = (AW + 2 > 8) ? AW + 2 : 8;
	localparam int PR_W  = css_pkg::COEF_W + css_pkg::PW_W + 1;
	localparam int MP_W  = COORD_BITS + css_pkg::WQ_W;
	localparam int SUM_W = MP_W + 2;

	localparam logic [IXW-1:0] MAXP = IXW'(MAX_POINTS);
	localparam logic signed [SUM_W-1:0] C_HALF = SUM_W'(64'sd1 <<< (css_pkg::CSHIFT - 1));
	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(64'sd1);

	// configuration registers
	logic [css_pkg::TEN_W-1:0] tension_q;
	logic [css_pkg::PIU_W-1:0] points_q;

	// item and working registers
	logic [css_pkg::T_W-1:0]            t_q;
	logic [css_pkg::IDX_W-1:0]          idx_q;
	logic [css_pkg::PW_W-1:0]           t2_q;
	logic [css_pkg::PW_W-1:0]           t3_q;
	logic signed [css_pkg::WACC_W-1:0]  wacc_q [4];
	logic signed [css_pkg::WQ_W-1:0]    wq_q [4];
	logic [2*COORD_BITS-1:0]            mem_q [MAX_POINTS];
	logic [2*COORD_BITS-1:0]            rd_q;
	logic signed [SUM_W-1:0]            sx_q;
	logic signed [SUM_W-1:0]            sy_q;
	logic signed [COORD_BITS-1:0]       out_x_q;
	logic signed [COORD_BITS-1:0]       out_y_q;
	logic                               out_valid_q;

	// combinational signals
	logic [IXW-1:0]                     wr_idx;
	logic                               wr_ok;
	logic [IXW-1:0]                     n_raw, n_eff, last;
	logic [IXW-1:0]                     rsum, rpos, rclamp;
	logic [css_pkg::PW_W-1:0]           pw;
	logic signed [css_pkg::PW_W:0]      pw_s;
	logic [css_pkg::PW_W+css_pkg::T_W-1:0] t3_full;
	logic signed [PR_W-1:0]             wprod [4];
	logic signed [css_pkg::WACC_W-1:0]  wnext [4];
	logic signed [css_pkg::WACC_W-1:0]  wrnd [4];
	logic signed [css_pkg::WQ_W-1:0]    wq_sel;
	logic signed [COORD_BITS-1:0]       rd_x, rd_y;
	logic signed [MP_W-1:0]             prod_x, prod_y;
	logic signed [SUM_W-1:0]            rx_add, ry_add, rx, ry, satx, saty;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= css_pkg::TENSION_RESET;
			points_q  <= css_pkg::POINTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				css_pkg::REG_TENSION: tension_q <= cfg_data[css_pkg::TEN_W-1:0];
				css_pkg::REG_POINTS:  points_q  <= cfg_data[css_pkg::PIU_W-1:0];
				default: ;
			endcase
		end
	end

	// write slot check and clamped read address
	assign wr_idx = IXW'(in_index);
	assign wr_ok  = wr_idx < MAXP;
	assign n_raw  = IXW'(points_q);
	assign n_eff  = (n_raw == '0) ? IXW'(1) : ((n_raw > MAXP) ? MAXP : n_raw);
	assign last   = n_eff - IXW'(1);
	assign rsum   = IXW'(idx_q) + IXW'(cmd.rd_k);
	assign rpos   = (rsum == '0) ? '0 : rsum - IXW'(1);
	assign rclamp = (rpos > last) ? last : rpos;

	// control point memory
	always_ff @(posedge clk) begin
		if (cmd.wr && wr_ok) begin
			mem_q[wr_idx[AW-1:0]] <= {in_y, in_x};
		end
		if (cmd.rd) begin
			rd_q <= mem_q[rclamp[AW-1:0]];
		end
	end

	// power of t for the current weight step
	always_comb begin
		case (cmd.wstep)
			css_pkg::WS_T1: pw = {t_q, {css_pkg::T_W{1'b0}}};
			css_pkg::WS_T2: pw = t2_q;
			default:        pw = t3_q;
		endcase
	end

	assign pw_s    = $signed({1'b0, pw});
	assign t3_full = t2_q * t_q;

	// weight products, one unit per weight, and rounding to Q.24
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			wprod[k] = css_pkg::wcoef(2'(k), cmd.wstep, tension_q) * pw_s;
			wnext[k] = ((cmd.wstep == css_pkg::WS_T1) ?
				((k == 1) ? css_pkg::W_ONE : '0) : wacc_q[k])
				+ css_pkg::WACC_W'(wprod[k]);
			wrnd[k]  = wacc_q[k] + css_pkg::W_HALF;
		end
	end

	// position products for the point in the read register
	assign wq_sel = wq_q[cmd.mstep];
	assign rd_x   = $signed(rd_q[COORD_BITS-1:0]);
	assign rd_y   = $signed(rd_q[2*COORD_BITS-1:COORD_BITS]);
	assign prod_x = rd_x * wq_sel;
	assign prod_y = rd_y * wq_sel;

	// rounding to Q.8 and saturation
	assign rx_add = sx_q + C_HALF;
	assign ry_add = sy_q + C_HALF;
	assign rx     = rx_add >>> css_pkg::CSHIFT;
	assign ry     = ry_add >>> css_pkg::CSHIFT;
	assign satx   = (rx > SAT_HI) ? SAT_HI : ((rx < SAT_LO) ? SAT_LO : rx);
	assign saty   = (ry > SAT_HI) ? SAT_HI : ((ry < SAT_LO) ? SAT_LO : ry);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q   <= in_t;
			idx_q <= in_index;
		end
		if (cmd.wgt && cmd.wstep == css_pkg::WS_T1) begin
			t2_q <= css_pkg::PW_W'(t_q * t_q);
		end
		if (cmd.wgt && cmd.wstep == css_pkg::WS_T2) begin
			t3_q <= t3_full[css_pkg::PW_W+css_pkg::T_W-1:css_pkg::T_W];
		end
		if (cmd.wgt) begin
			for (int k = 0; k < 4; k++) begin
				wacc_q[k] <= wnext[k];
			end
		end
		if (cmd.rnd) begin
			for (int k = 0; k < 4; k++) begin
				wq_q[k] <= wrnd[k][css_pkg::WACC_W-1:css_pkg::WSHIFT];
			end
		end
		if (cmd.mac) begin
			sx_q <= ((cmd.mstep == 2'd0) ? '0 : sx_q) + SUM_W'(prod_x);
			sy_q <= ((cmd.mstep == 2'd0) ? '0 : sy_q) + SUM_W'(prod_y);
		end
		if (cmd.fin) begin
			out_x_q <= satx[COORD_BITS-1:0];
			out_y_q <= saty[COORD_BITS-1:0];
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;

	// every point step uses a read issued the cycle before
	a_rd_before_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac |-> $past(cmd.rd))
		else $error("point step without preceding memory read");

	// weights are rounded only right after their last term
	a_rnd_after_wgt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rnd |-> $past(cmd.wgt && cmd.wstep == css_pkg::WS_T3))
		else $error("weight rounding before last weight term");

	// a new result appears only from a finish command
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.fin))
		else $error("result valid without finish command");

endmodule

`default_nettype wire

/* rtl/cardinal_spline_segment_eval.sv */
// Top level of the cardinal spline segment evaluator: port packing around
// the controller and datapath. Depends on css_pkg, css_ctrl and css_dp.
`default_nettype none

// The block holds a table of MAX_POINTS 2D control points in one memory with a
// single registered read port. A write item (tuser 0) stores a point when it is
// transferred and the block takes the next item in the following cycle; writes
// to a slot at or beyond MAX_POINTS are dropped. An evaluate item (tuser 1) runs
// through weight terms (t, t^2, t^3 on four weight multipliers), a rounding
// step, the position sum with the one memory read port feeding one point per
// cycle, and rounding and saturation into the output register. The block takes
// the next item only once that result is loaded. The result may wait in the
// output register while the next item runs; a following evaluate stalls only in
// its last cycle if the previous result is still untaken. Points read at clamped
// indices i-1..i+2 must have been written. Configuration is to be written only
// while idle by the user; the block itself does not enforce it.
module cardinal_spline_segment_eval #(
	parameter int MAX_POINTS = css_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = css_pkg::COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// input stream
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// point_index, point_x, point_y, param_t
	input  wire logic [((22 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// action
	input  wire logic s_axis_tuser,
	// result stream
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// pos_x, pos_y
	output logic [((2*COORD_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [css_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [css_pkg::CFG_W-1:0]     cfg_data
);

	localparam int M_DATA_W = ((2*COORD_BITS + 7) / 8) * 8;
	localparam int X_LO     = css_pkg::IDX_W;
	localparam int Y_LO     = X_LO + COORD_BITS;
	localparam int T_LO     = Y_LO + COORD_BITS;

	css_pkg::dp_cmd_t             cmd;
	css_pkg::dp_sts_t             sts;
	logic signed [COORD_BITS-1:0] pos_x, pos_y;

	css_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.sts       (sts),
		.cmd       (cmd)
	);

	css_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_index  (s_axis_tdata[css_pkg::IDX_W-1:0]),
		.in_x      ($signed(s_axis_tdata[X_LO +: COORD_BITS])),
		.in_y      ($signed(s_axis_tdata[Y_LO +: COORD_BITS])),
		.in_t      (s_axis_tdata[T_LO +: css_pkg::T_W]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (pos_x),
		.out_y     (pos_y)
	);

	// result packing, zero filled to whole bytes
	assign m_axis_tdata = M_DATA_W'({pos_y, pos_x});

endmodule

`default_nettype wire
